// File: rtl/core/dtc_pkg.sv
// dtc_pkg: types, codes and width helpers for the die temperature calibration block
// no dependencies; imported by every module under rtl/core
`default_nettype none

package dtc_pkg;

    localparam int COEF_W        = 16;
    localparam int NUM_CHAN      = 2;
    localparam int CFG_ADDR_W    = 3;
    localparam int CODE_W        = 12;
    localparam int CHAN_W        = 2;
    localparam int TEMP_W        = 16;
    localparam int KELVIN_OFFSET = 27315;
    localparam int SENSOR_SHIFT  = 4;
    localparam int BANDGAP_SHIFT = 2;
    // 12800 = 100 * 128 = 2^13 + 2^12 + 2^9
    localparam int SCALE_SH_HI   = 13;
    localparam int SCALE_SH_MID  = 12;
    localparam int SCALE_SH_LO   = 9;
    localparam int SCALE_W       = 14;
    // top quotient bit marks a magnitude of 65536 or more
    localparam int QUOT_W        = 17;
    localparam int FRONT_STAGES  = 5;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAN = 2'd1,
        ST_ZERO_DEN = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_A = 2'd0,
        REG_B = 2'd1,
        REG_C = 2'd2,
        REG_D = 2'd3
    } t_coef_sel;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } t_coef_set;

    typedef struct packed {
        logic bad_chan;
        logic zero_den;
        logic neg;
    } t_tag;

    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_ctrl;

    function automatic int prod_w(input int cb);
        return COEF_W + cb;
    endfunction

    function automatic int num0_w(input int cb);
        return prod_w(cb) + SENSOR_SHIFT + 1;
    endfunction

    function automatic int num_w(input int cb);
        return num0_w(cb) + SCALE_W;
    endfunction

    function automatic int den_w(input int cb);
        return prod_w(cb) + BANDGAP_SHIFT + 1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtc_front.sv
// dtc_front: coefficient registers, channel select, products, sums and magnitudes
// depends on dtc_pkg; feeds the first divider cell
`default_nettype none

module dtc_front import dtc_pkg::*; #(
    parameter int CODE_BITS = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]           i_cfg_index,
    input  wire logic [COEF_W-1:0]               i_cfg_wdata,
    input  wire logic                            i_valid,
    input  wire logic [CHAN_W-1:0]               i_chan,
    input  wire logic [CODE_W-1:0]               i_bg,
    input  wire logic [CODE_W-1:0]               i_ts,
    input  wire logic [FRONT_STAGES-1:0]         i_go,
    output logic      [FRONT_STAGES-1:0]         o_valid,
    output t_ctrl                                o_ctrl,
    output logic      [num_w(CODE_BITS)-1:0]     o_rem,
    output logic      [den_w(CODE_BITS)-1:0]     o_den
);

    localparam int PROD_W = prod_w(CODE_BITS);
    localparam int NUM0_W = num0_w(CODE_BITS);
    localparam int NUM_W  = num_w(CODE_BITS);
    localparam int DEN_W  = den_w(CODE_BITS);

    t_coef_set r_coef [NUM_CHAN];

    logic [FRONT_STAGES-1:0] r_valid;

    t_coef_set               r0_coef;
    logic [CODE_BITS-1:0]    r0_bg;
    logic [CODE_BITS-1:0]    r0_ts;
    logic                    r0_bad;

    logic signed [PROD_W-1:0] r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [PROD_W-1:0] n1_pa, n1_pb, n1_pc, n1_pd;
    logic                     r1_bad;

    logic signed [NUM0_W-1:0] r2_num0;
    logic signed [DEN_W-1:0]  r2_den;
    logic                     r2_bad;

    logic signed [NUM_W-1:0]  r3_num;
    logic [DEN_W-1:0]         r3_den_mag;
    logic                     r3_den_neg;
    logic                     r3_zero;
    logic                     r3_bad;

    logic [NUM_W-1:0]         r4_num_mag;
    logic [DEN_W-1:0]         r4_den_mag;
    t_tag                     r4_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '{default: '0};
        end else if (i_cfg_wr_en) begin
            unique case (t_coef_sel'(i_cfg_index[1:0]))
                REG_A:   r_coef[i_cfg_index[CFG_ADDR_W-1]].a <= i_cfg_wdata;
                REG_B:   r_coef[i_cfg_index[CFG_ADDR_W-1]].b <= i_cfg_wdata;
                REG_C:   r_coef[i_cfg_index[CFG_ADDR_W-1]].c <= i_cfg_wdata;
                REG_D:   r_coef[i_cfg_index[CFG_ADDR_W-1]].d <= i_cfg_wdata;
                default: r_coef[i_cfg_index[CFG_ADDR_W-1]].a <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_go[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int i = 1; i < FRONT_STAGES; i++) begin
                if (i_go[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    always_comb begin
        n1_pa = PROD_W'(r0_coef.a) * PROD_W'($signed({1'b0, r0_bg}));
        n1_pb = PROD_W'(r0_coef.b) * PROD_W'($signed({1'b0, r0_ts}));
        n1_pc = PROD_W'(r0_coef.c) * PROD_W'($signed({1'b0, r0_bg}));
        n1_pd = PROD_W'(r0_coef.d) * PROD_W'($signed({1'b0, r0_ts}));
    end

    always_ff @(posedge i_clk) begin
        if (i_go[0]) begin
            r0_coef <= r_coef[i_chan[0]];
            r0_bg   <= i_bg[CODE_BITS-1:0];
            r0_ts   <= i_ts[CODE_BITS-1:0];
            r0_bad  <= i_chan[CHAN_W-1];
        end
        if (i_go[1]) begin
            r1_pa  <= n1_pa;
            r1_pb  <= n1_pb;
            r1_pc  <= n1_pc;
            r1_pd  <= n1_pd;
            r1_bad <= r0_bad;
        end
        if (i_go[2]) begin
            r2_num0 <= NUM0_W'(r1_pa) + (NUM0_W'(r1_pb) <<< SENSOR_SHIFT);
            r2_den  <= (DEN_W'(r1_pc) <<< BANDGAP_SHIFT) + DEN_W'(r1_pd);
            r2_bad  <= r1_bad;
        end
        if (i_go[3]) begin
            r3_num     <= (NUM_W'(r2_num0) <<< SCALE_SH_HI)
                        + (NUM_W'(r2_num0) <<< SCALE_SH_MID)
                        + (NUM_W'(r2_num0) <<< SCALE_SH_LO);
            r3_den_mag <= r2_den[DEN_W-1] ? DEN_W'(-r2_den) : DEN_W'(r2_den);
            r3_den_neg <= r2_den[DEN_W-1];
            r3_zero    <= (r2_den == '0);
            r3_bad     <= r2_bad;
        end
        if (i_go[4]) begin
            r4_num_mag      <= r3_num[NUM_W-1] ? NUM_W'(-r3_num) : NUM_W'(r3_num);
            r4_den_mag      <= r3_den_mag;
            r4_tag.neg      <= r3_num[NUM_W-1] ^ r3_den_neg;
            r4_tag.zero_den <= r3_zero;
            r4_tag.bad_chan <= r3_bad;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = '{valid: r_valid[FRONT_STAGES-1], tag: r4_tag};
    assign o_rem   = r4_num_mag;
    assign o_den   = r4_den_mag;

endmodule

`default_nettype wire

// File: rtl/core/dtc_div_cell.sv
// dtc_div_cell: one restoring divide step, produces one quotient bit per item
// depends on dtc_pkg; chained by the top level, most significant bit first
`default_nettype none

module dtc_div_cell import dtc_pkg::*; #(
    parameter int REM_W  = 47,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 17,
    parameter int SHIFT  = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [Q_W-1:0]   i_quot,
    output t_ctrl                 o_ctrl,
    output logic      [REM_W-1:0] o_rem,
    output logic      [DEN_W-1:0] o_den,
    output logic      [Q_W-1:0]   o_quot
);

    localparam int CMP_W = (REM_W > DEN_W + SHIFT) ? REM_W : DEN_W + SHIFT;

    logic [CMP_W-1:0] ext_rem, ext_den, diff;
    logic             fits;
    logic [REM_W-1:0] n_rem;
    logic [Q_W-1:0]   n_quot;

    logic             r_valid;
    t_tag             r_tag;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quot;

    always_comb begin
        ext_rem       = CMP_W'(i_rem);
        ext_den       = CMP_W'(i_den) << SHIFT;
        fits          = (ext_rem >= ext_den);
        diff          = ext_rem - ext_den;
        n_rem         = fits ? diff[REM_W-1:0] : i_rem;
        n_quot        = i_quot;
        n_quot[SHIFT] = fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_go) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_tag  <= i_ctrl.tag;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
        end
    end

    assign o_ctrl = '{valid: r_valid, tag: r_tag};
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: rtl/core/dtc_out.sv
// dtc_out: sign, offset, saturation and status, plus the output register
// depends on dtc_pkg; takes the quotient from the last divider cell
`default_nettype none

module dtc_out import dtc_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_go,
    input  wire t_ctrl                    i_ctrl,
    input  wire logic [QUOT_W-1:0]        i_quot,
    output logic                          o_valid,
    output logic signed [TEMP_W-1:0]      o_temp,
    output t_status                       o_status
);

    localparam int SUM_W = QUOT_W + 1;

    logic                    ovf;
    logic signed [SUM_W-1:0] mag, sval, tval;
    logic signed [TEMP_W-1:0] n_temp;
    t_status                  n_status;

    logic                     r_valid;
    logic signed [TEMP_W-1:0] r_temp;
    t_status                  r_status;

    always_comb begin
        ovf  = i_quot[QUOT_W-1];
        mag  = $signed({2'b00, i_quot[QUOT_W-2:0]});
        sval = i_ctrl.tag.neg ? -mag : mag;
        tval = sval - SUM_W'(KELVIN_OFFSET);
        priority if (i_ctrl.tag.bad_chan) begin
            n_temp   = '0;
            n_status = ST_BAD_CHAN;
        end else if (i_ctrl.tag.zero_den) begin
            n_temp   = '0;
            n_status = ST_ZERO_DEN;
        end else if (ovf) begin
            n_temp   = i_ctrl.tag.neg ? TEMP_MIN : TEMP_MAX;
            n_status = ST_SAT;
        end else if (tval > SUM_W'(TEMP_MAX)) begin
            n_temp   = TEMP_MAX;
            n_status = ST_SAT;
        end else if (tval < SUM_W'(TEMP_MIN)) begin
            n_temp   = TEMP_MIN;
            n_status = ST_SAT;
        end else begin
            n_temp   = tval[TEMP_W-1:0];
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_go) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_temp   <= n_temp;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_temp   = r_temp;
    assign o_status = r_status;

endmodule

`default_nettype wire

// File: rtl/core/die_temperature_calibration_top.sv
// die_temperature_calibration_top: converter codes to die temperature in 0.01 deg C
// depends on dtc_pkg, dtc_front, dtc_div_cell, dtc_out
//
//  channel  | direction | tdata (low bit up)                 | tuser
//  s side   | in        | bandgap_code[11:0], sensor_code    | sensor_channel
//  m side   | out       | temperature_centideg               | status
//  cfg      | in        | write enable, index 0..7, 16-bit coefficient
//
//  one item per cycle while the m side is ready; 5 front stages, 17 divider cells
//  (one quotient bit each), 1 output stage
//  each stage loads when it is empty or its successor moves, so bubbles
//  close up and input is taken while a result waits at the output
//  synchronous active-low reset clears all valid bits and the coefficients
`default_nettype none

module die_temperature_calibration_top import dtc_pkg::*; #(
    parameter int CODE_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  wire logic [COEF_W-1:0]     i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [2*CODE_W-1:0]   i_s_tdata,  // bandgap_code, sensor_code
    input  wire logic [CHAN_W-1:0]     i_s_tuser,  // sensor_channel
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [TEMP_W-1:0]          o_m_tdata,  // temperature_centideg
    output logic [1:0]                 o_m_tuser   // status
);

    localparam int NUM_W = num_w(CODE_BITS);
    localparam int DEN_W = den_w(CODE_BITS);
    localparam int NST   = FRONT_STAGES + QUOT_W + 1;

    logic [NST-1:0] v, go;

    t_ctrl             c_ctrl [QUOT_W+1];
    logic [NUM_W-1:0]  c_rem  [QUOT_W+1];
    logic [DEN_W-1:0]  c_den  [QUOT_W+1];
    logic [QUOT_W-1:0] c_quot [QUOT_W+1];

    logic                     out_valid;
    logic signed [TEMP_W-1:0] out_temp;
    t_status                  out_status;

    assign go[NST-1] = !v[NST-1] || i_m_tready;

    for (genvar i = 0; i < NST - 1; i++) begin : g_go
        assign go[i] = !v[i] || go[i+1];
    end

    dtc_front #(
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_chan      (i_s_tuser),
        .i_bg        (i_s_tdata[CODE_W-1:0]),
        .i_ts        (i_s_tdata[2*CODE_W-1:CODE_W]),
        .i_go        (go[FRONT_STAGES-1:0]),
        .o_valid     (v[FRONT_STAGES-1:0]),
        .o_ctrl      (c_ctrl[0]),
        .o_rem       (c_rem[0]),
        .o_den       (c_den[0])
    );

    assign c_quot[0] = '0;

    for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
        dtc_div_cell #(
            .REM_W (NUM_W),
            .DEN_W (DEN_W),
            .Q_W   (QUOT_W),
            .SHIFT (QUOT_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (go[FRONT_STAGES+k]),
            .i_ctrl  (c_ctrl[k]),
            .i_rem   (c_rem[k]),
            .i_den   (c_den[k]),
            .i_quot  (c_quot[k]),
            .o_ctrl  (c_ctrl[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_den   (c_den[k+1]),
            .o_quot  (c_quot[k+1])
        );
        assign v[FRONT_STAGES+k] = c_ctrl[k+1].valid;
    end

    dtc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go[NST-1]),
        .i_ctrl   (c_ctrl[QUOT_W]),
        .i_quot   (c_quot[QUOT_W]),
        .o_valid  (out_valid),
        .o_temp   (out_temp),
        .o_status (out_status)
    );

    assign v[NST-1]    = out_valid;
    assign o_s_tready  = go[0];
    assign o_m_tvalid  = out_valid;
    assign o_m_tdata   = out_temp;
    assign o_m_tuser   = out_status;

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> v == '0)
        else $error("pipeline valid bits not cleared by reset");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_SAT |->
            o_m_tdata == TEMP_MAX || o_m_tdata == TEMP_MIN)
        else $error("saturated item carries a non-limit value");

    a_ovf_to_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go[NST-1] && c_ctrl[QUOT_W].valid && c_quot[QUOT_W][QUOT_W-1]
            && !c_ctrl[QUOT_W].tag.zero_den && !c_ctrl[QUOT_W].tag.bad_chan
        |=> o_m_tuser == ST_SAT)
        else $error("quotient overflow did not saturate");
`endif

endmodule

`default_nettype wire
